### sv/source_tagged_slot_buffer_macros.svh
// Assertion macros shared by the slot buffer modules.
// Both expect clk and arst_n in the enclosing module.
`ifndef SOURCE_TAGGED_SLOT_BUFFER_MACROS_SVH
`define SOURCE_TAGGED_SLOT_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STSB_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STSB_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/stsb_pkg.sv
`default_nettype none

package stsb_pkg;

	localparam int BUF_SLOTS     = 16;
	localparam int NUM_SOURCES   = 16;
	localparam int DEF_PAYLOAD_W = 32;

	localparam int SLOT_W = $clog2(BUF_SLOTS);
	localparam int SRC_W  = $clog2(NUM_SOURCES);
	localparam int CNT_W  = $clog2(BUF_SLOTS + 1);
	localparam int CFG_W  = 5;

	localparam logic [CFG_W-1:0] DEF_ACTIVE = CFG_W'(BUF_SLOTS);

	typedef enum logic [1:0] {
		REQ_FIND_EMPTY  = 2'd0,
		REQ_FIND_SOURCE = 2'd1,
		REQ_PUSH        = 2'd2,
		REQ_PULL        = 2'd3
	} stsb_req_t;

	typedef enum logic [1:0] {
		STAT_OK         = 2'd0,
		STAT_NOT_FOUND  = 2'd1,
		STAT_PULL_EMPTY = 2'd2
	} stsb_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_SCAN,
		ST_PUSH_A,
		ST_PUSH_B,
		ST_PULL,
		ST_RESULT
	} stsb_state_t;

	typedef struct packed {
		logic accept;
		logic set_nf;
		logic scan;
		logic push_a;
		logic push_b;
		logic pull;
		logic load_out;
	} stsb_cmd_t;

	typedef struct packed {
		stsb_req_t req;
		logic      pos_bad;
		logic      sid_bad;
		logic      scan_hit;
		logic      scan_last;
	} stsb_sts_t;

endpackage

`default_nettype wire

### sv/stsb_ctrl.sv
`default_nettype none
`include "source_tagged_slot_buffer_macros.svh"

module stsb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	input  wire stsb_pkg::stsb_sts_t sts,
	output stsb_pkg::stsb_cmd_t   cmd
);
	import stsb_pkg::*;

	stsb_state_t state_q;
	stsb_state_t state_nxt;
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				if (sts.pos_bad) begin
					cmd.set_nf = 1'b1;
					state_nxt  = ST_RESULT;
				end else begin
					case (sts.req)
						REQ_FIND_EMPTY:  state_nxt = ST_SCAN;
						REQ_FIND_SOURCE: state_nxt = ST_SCAN;
						REQ_PUSH: begin
							if (sts.sid_bad) begin
								cmd.set_nf = 1'b1;
								state_nxt  = ST_RESULT;
							end else begin
								state_nxt = ST_PUSH_A;
							end
						end
						REQ_PULL:        state_nxt = ST_PULL;
						default:         state_nxt = ST_RESULT;
					endcase
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_hit || sts.scan_last) begin
					state_nxt = ST_RESULT;
				end
			end
			ST_PUSH_A: begin
				cmd.push_a = 1'b1;
				state_nxt  = ST_PUSH_B;
			end
			ST_PUSH_B: begin
				cmd.push_b = 1'b1;
				state_nxt  = ST_RESULT;
			end
			ST_PULL: begin
				cmd.pull  = 1'b1;
				state_nxt = ST_RESULT;
			end
			ST_RESULT: begin
				// The output register may be refilled in the cycle its beat leaves.
				if (!out_valid_q || !out_stall) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	`STSB_ASSERT_NEXT(a_accept_dispatch, in_valid && !in_stall, state_q == ST_DISPATCH, "accepted beat did not start dispatch")
	`STSB_ASSERT_NOW(a_load_free, cmd.load_out, !out_valid_q || !out_stall, "result loaded over a waiting beat")
	`STSB_ASSERT_NOW(a_rise_from_result, $rose(out_valid_q), $past(state_q) == ST_RESULT, "output beat raised outside result state")

endmodule

`default_nettype wire

### sv/stsb_datapath.sv
`default_nettype none
`include "source_tagged_slot_buffer_macros.svh"

module stsb_datapath #(
	parameter int PAYLOAD_W = stsb_pkg::DEF_PAYLOAD_W
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [stsb_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic [1:0]                  req_type,
	input  wire logic [stsb_pkg::SLOT_W-1:0] position,
	input  wire logic [stsb_pkg::SRC_W-1:0]  source_id,
	input  wire logic [PAYLOAD_W-1:0]        payload,
	input  wire stsb_pkg::stsb_cmd_t         cmd,
	output stsb_pkg::stsb_sts_t              sts,
	output logic                             found,
	output logic [stsb_pkg::SLOT_W-1:0]      result_position,
	output logic [stsb_pkg::SRC_W-1:0]       out_source_id,
	output logic [PAYLOAD_W-1:0]             out_payload,
	output logic [stsb_pkg::CNT_W-1:0]       fill_count,
	output logic [stsb_pkg::SRC_W-1:0]       min_source,
	output logic [1:0]                       status
);
	import stsb_pkg::*;

	// Configuration and buffer state.
	logic [CFG_W-1:0]     active_q;
	logic [SRC_W-1:0]     slot_src_q [BUF_SLOTS];
	logic [PAYLOAD_W-1:0] slot_pay_mem [BUF_SLOTS];
	logic [PAYLOAD_W-1:0] pay_rd_q;
	logic [CNT_W-1:0]     src_cnt_q [NUM_SOURCES];
	logic [CNT_W-1:0]     total_q;

	// Current request.
	stsb_req_t            req_q;
	logic [SLOT_W-1:0]    ptr_q;
	logic [SLOT_W-1:0]    step_q;
	logic [SRC_W-1:0]     sid_q;
	logic [PAYLOAD_W-1:0] pay_q;

	// Result being built.
	logic                 found_q;
	logic [SLOT_W-1:0]    rpos_q;
	logic [SRC_W-1:0]     osid_q;
	stsb_status_t         stat_q;
	logic                 pull_ok_q;

	// Output register.
	logic                 out_found_q;
	logic [SLOT_W-1:0]    out_rpos_q;
	logic [SRC_W-1:0]     out_sid_q;
	logic [PAYLOAD_W-1:0] out_pay_q;
	logic [CNT_W-1:0]     out_fill_q;
	logic [SRC_W-1:0]     out_min_q;
	stsb_status_t         out_stat_q;

	logic [CNT_W-1:0]       n_used;
	logic [CNT_W-1:0]       last_idx;
	logic [SRC_W-1:0]       cur_src;
	logic [SRC_W-1:0]       target;
	logic [SLOT_W-1:0]      ptr_next;
	logic [SRC_W-1:0]       cnt_addr;
	logic [CNT_W-1:0]       cnt_rd;
	logic [NUM_SOURCES-1:0] src_nz;
	logic [SRC_W-1:0]       min_src;

	// A zero register value means one slot; values past the buffer are clipped.
	always_comb begin
		if (active_q == '0) begin
			n_used = CNT_W'(1);
		end else if (active_q > CFG_W'(BUF_SLOTS)) begin
			n_used = CNT_W'(BUF_SLOTS);
		end else begin
			n_used = CNT_W'(active_q);
		end
	end

	assign last_idx = n_used - 1'b1;
	assign cur_src  = slot_src_q[ptr_q];
	// Searching for source zero is the same as searching for an empty slot.
	assign target   = (req_q == REQ_FIND_EMPTY) ? '0 : sid_q;
	assign ptr_next = (CNT_W'(ptr_q) == last_idx) ? '0 : ptr_q + 1'b1;
	assign cnt_addr = cmd.push_b ? sid_q : cur_src;
	assign cnt_rd   = src_cnt_q[cnt_addr];

	always_comb begin
		sts.req       = req_q;
		sts.pos_bad   = (CNT_W'(ptr_q) >= n_used);
		sts.sid_bad   = (sid_q == '0) || (int'(sid_q) >= NUM_SOURCES);
		sts.scan_hit  = (cur_src == target);
		if (req_q == REQ_FIND_EMPTY) begin
			sts.scan_last = (CNT_W'(step_q) == last_idx);
		end else begin
			sts.scan_last = (CNT_W'(ptr_q) == last_idx);
		end
	end

	always_comb begin
		for (int s = 0; s < NUM_SOURCES; s++) begin
			src_nz[s] = (src_cnt_q[s] != '0);
		end
	end

	always_comb begin
		min_src = '0;
		for (int s = NUM_SOURCES - 1; s >= 1; s--) begin
			if (src_nz[s]) begin
				min_src = SRC_W'(s);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= DEF_ACTIVE;
			total_q  <= '0;
			for (int i = 0; i < BUF_SLOTS; i++) begin
				slot_src_q[i] <= '0;
			end
			for (int s = 0; s < NUM_SOURCES; s++) begin
				src_cnt_q[s] <= '0;
			end
		end else if (cfg_we) begin
			// Resizing rebuilds the buffer empty.
			active_q <= cfg_data;
			total_q  <= '0;
			for (int i = 0; i < BUF_SLOTS; i++) begin
				slot_src_q[i] <= '0;
			end
			for (int s = 0; s < NUM_SOURCES; s++) begin
				src_cnt_q[s] <= '0;
			end
		end else begin
			if (cmd.push_a) begin
				slot_src_q[ptr_q] <= sid_q;
				if (cur_src == '0) begin
					total_q <= total_q + 1'b1;
				end else if (cnt_rd != '0) begin
					src_cnt_q[cnt_addr] <= cnt_rd - 1'b1;
				end
			end
			// The new source is counted in the cycle after the old one is released.
			if (cmd.push_b) begin
				src_cnt_q[cnt_addr] <= cnt_rd + 1'b1;
			end
			if (cmd.pull && (cur_src != '0)) begin
				slot_src_q[ptr_q] <= '0;
				if (cnt_rd != '0) begin
					src_cnt_q[cnt_addr] <= cnt_rd - 1'b1;
				end
				if (total_q != '0) begin
					total_q <= total_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push_a) begin
			slot_pay_mem[ptr_q] <= pay_q;
		end
		pay_rd_q <= slot_pay_mem[ptr_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q     <= stsb_req_t'(req_type);
			ptr_q     <= position;
			step_q    <= '0;
			sid_q     <= source_id;
			pay_q     <= payload;
			found_q   <= 1'b0;
			rpos_q    <= '0;
			osid_q    <= '0;
			stat_q    <= STAT_OK;
			pull_ok_q <= 1'b0;
		end
		if (cmd.set_nf) begin
			stat_q <= STAT_NOT_FOUND;
		end
		if (cmd.scan) begin
			if (sts.scan_hit) begin
				found_q <= 1'b1;
				rpos_q  <= ptr_q;
			end else if (sts.scan_last) begin
				stat_q <= STAT_NOT_FOUND;
			end else begin
				ptr_q  <= ptr_next;
				step_q <= step_q + 1'b1;
			end
		end
		if (cmd.pull) begin
			if (cur_src == '0) begin
				stat_q <= STAT_PULL_EMPTY;
			end else begin
				osid_q    <= cur_src;
				pull_ok_q <= 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_found_q <= found_q;
			out_rpos_q  <= rpos_q;
			out_sid_q   <= osid_q;
			out_pay_q   <= pull_ok_q ? pay_rd_q : '0;
			out_fill_q  <= total_q;
			out_min_q   <= min_src;
			out_stat_q  <= stat_q;
		end
	end

	assign found           = out_found_q;
	assign result_position = out_rpos_q;
	assign out_source_id   = out_sid_q;
	assign out_payload     = out_pay_q;
	assign fill_count      = out_fill_q;
	assign min_source      = out_min_q;
	assign status          = out_stat_q;

	`STSB_ASSERT_NOW(a_scan_ptr_range, cmd.scan, CNT_W'(ptr_q) < n_used, "scan pointer left the active slots")
	`STSB_ASSERT_NOW(a_scan_step_range, cmd.scan, CNT_W'(step_q) < n_used, "scan ran past one full lap")
	`STSB_ASSERT_NOW(a_fill_bound, 1'b1, total_q <= n_used, "fill count exceeds active slots")

endmodule

`default_nettype wire

### sv/source_tagged_slot_buffer.sv
// Source-tagged slot buffer: up to 16 slots, each holding a source id and a payload.
// Input channel (in_valid/in_stall) takes one request beat: find_empty, find_source,
// push or pull. Output channel (out_valid/out_stall) returns one result beat per request,
// carrying the search hit, the pulled item, the fill count and the lowest busy source.
// Requests are served one at a time. From acceptance, a request goes to a dispatch state,
// then straight to the result state for an out-of-range position or ignored push, through
// the pull state for a pull, through the PUSH_A and PUSH_B states for a push, and through
// the scan state for a search, which examines up to the number of active slots, one slot
// per cycle. The next request is accepted in the cycle after the result is loaded.
// A finished result waits in the output register while out_stall is high; a new request
// is still taken, and its result is held back until the waiting beat leaves.
// cfg_we writes active_slots and empties every slot and count in the same cycle; write
// it only while no request is in flight. Reset (arst_n low) empties the buffer, sets
// active_slots to 16 and drops any pending result.
`default_nettype none

module source_tagged_slot_buffer #(
	parameter int PAYLOAD_W = stsb_pkg::DEF_PAYLOAD_W
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [stsb_pkg::CFG_W-1:0]  cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [1:0]                  req_type,
	input  wire logic [stsb_pkg::SLOT_W-1:0] position,
	input  wire logic [stsb_pkg::SRC_W-1:0]  source_id,
	input  wire logic [PAYLOAD_W-1:0]        payload,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic                             found,
	output logic [stsb_pkg::SLOT_W-1:0]      result_position,
	output logic [stsb_pkg::SRC_W-1:0]       out_source_id,
	output logic [PAYLOAD_W-1:0]             out_payload,
	output logic [stsb_pkg::CNT_W-1:0]       fill_count,
	output logic [stsb_pkg::SRC_W-1:0]       min_source,
	output logic [1:0]                       status
);
	import stsb_pkg::*;

	stsb_cmd_t cmd;
	stsb_sts_t sts;

	stsb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	stsb_datapath #(
		.PAYLOAD_W (PAYLOAD_W)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_data        (cfg_data),
		.req_type        (req_type),
		.position        (position),
		.source_id       (source_id),
		.payload         (payload),
		.cmd             (cmd),
		.sts             (sts),
		.found           (found),
		.result_position (result_position),
		.out_source_id   (out_source_id),
		.out_payload     (out_payload),
		.fill_count      (fill_count),
		.min_source      (min_source),
		.status          (status)
	);

endmodule

`default_nettype wire
